// ----- rtl/sbcs_pkg.sv -----
// Shared types and constants of the size-bucketed clause store.
package sbcs_pkg;

	localparam int KIND_W     = 3;
	localparam int HANDLE_W   = 16;
	localparam int SIZE_W     = 6;
	localparam int BUDGET_W   = 7;
	localparam int SEL_CNT_W  = 7;
	localparam int STORED_W   = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SELECT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GIVE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TOTAL  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_BUCKET = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LITERAL_BUDGET = 2'd1;

	localparam logic [BUDGET_W-1:0]   SELECT_CAP     = 7'd64;
	localparam logic [CFG_DATA_W-1:0] LIT_BUDGET_RST = 11'd1000;

	typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_SIZE, IDX_INC} idx_op_t;
	typedef enum logic [1:0] {CW_ZERO, CW_INC, CW_DEC, CW_PTR} cnt_wsel_t;
	typedef enum logic [1:0] {T_HOLD, T_INC, T_DEC, T_SUB_CNT} total_op_t;
	typedef enum logic [2:0] {P_HOLD, P_ZERO, P_CNT_M1, P_INC, P_DEC} ptr_op_t;
	typedef enum logic [2:0] {
		RES_NONE, RES_ACC, RES_TOTAL, RES_BUCKET, RES_GIVE, RES_SEL_ITEM, RES_SEL_LAST
	} res_t;

	typedef struct packed {
		logic      req_ready;
		idx_op_t   idx_op;
		logic      prod_add;
		logic      prod_sel;
		logic      cnt_we;
		cnt_wsel_t cnt_wsel;
		logic      h_we;
		total_op_t total_op;
		logic      left_sub_prod;
		logic      left_sub_s;
		ptr_op_t   ptr_op;
		logic      cw_load;
		logic      sel_init;
		logic      push;
		logic      out_load;
		res_t      out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic              req_valid;
		logic [KIND_W-1:0] kind;
		logic              size_zero;
		logic              size_ok;
		logic              size_over;
		logic              limit_ok;
		logic              cnt_zero;
		logic              add_fit;
		logic              left_lt_s;
		logic              whole_fit;
		logic              ptr_eq_cw;
		logic              idx_last;
		logic              pend_v;
		logic              out_free;
	} dp_sts_t;

endpackage

// ----- rtl/sbcs_if.sv -----
// Request, result and configuration channel interfaces.
interface sbcs_req_if;
	import sbcs_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [HANDLE_W-1:0] clause_handle;
	logic [SIZE_W-1:0]   clause_size;
	logic [BUDGET_W-1:0] budget;
	modport source (output valid, kind, clause_handle, clause_size, budget, input ready);
	modport sink (input valid, kind, clause_handle, clause_size, budget, output ready);
endinterface

interface sbcs_res_if;
	import sbcs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 has_clause;
	logic [HANDLE_W-1:0]  out_handle;
	logic [SIZE_W-1:0]    out_size;
	logic                 accepted;
	logic [BUDGET_W-1:0]  used_literals;
	logic [SEL_CNT_W-1:0] selected_count;
	logic [STORED_W-1:0]  stored_count;
	logic                 last;
	modport source (output valid, has_clause, out_handle, out_size, accepted, used_literals,
		selected_count, stored_count, last, input ready);
	modport sink (input valid, has_clause, out_handle, out_size, accepted, used_literals,
		selected_count, stored_count, last, output ready);
endinterface

interface sbcs_cfg_if;
	import sbcs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/sbcs_dp.sv -----
// Datapath: request registers, count and handle memories, select arithmetic, result register.
module sbcs_dp #(
	parameter int MAX_SIZE     = 32,
	parameter int BUCKET_DEPTH = 1024,
	parameter int HANDLE_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	sbcs_req_if.sink          req,
	sbcs_res_if.source        res,
	sbcs_cfg_if.sink          cfg,
	input  sbcs_pkg::dp_cmd_t cmd,
	output sbcs_pkg::dp_sts_t sts
);
	import sbcs_pkg::*;

	localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SW    = $clog2(MAX_SIZE + 1);
	localparam int CW    = $clog2(BUCKET_DEPTH + 1);
	localparam int HD    = MAX_SIZE * BUCKET_DEPTH;
	localparam int AW    = $clog2(HD);
	localparam int TW    = $clog2(HD + 1);
	localparam int PRW   = CW + SW;
	localparam int CMPW  = PRW + CFG_DATA_W + 1;

	// configuration
	logic [SIZE_W-1:0]     lim_q;
	logic [CFG_DATA_W-1:0] lit_q;

	// request
	logic [KIND_W-1:0]   kind_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SIZE_W-1:0]   size_q;
	logic [BUDGET_W-1:0] budget_q;

	// walk state
	logic [IW-1:0]       idx_q;
	logic [AW-1:0]       base_q;
	logic [CW-1:0]       cnt_rdata_q;
	logic [CW-1:0]       cw_q;
	logic [CW-1:0]       ptr_q;
	logic [PRW-1:0]      prod_q;
	logic [BUDGET_W-1:0] left_q;
	logic [SEL_CNT_W-1:0] n_q;
	logic [TW-1:0]       total_q;
	logic                pend_v_q;
	logic [HANDLE_BITS-1:0] pend_handle_q;
	logic [SW-1:0]       pend_size_q;
	logic [HANDLE_BITS-1:0] h_rdata_q;

	logic [CW-1:0]          cnt_mem [MAX_SIZE];
	logic [HANDLE_BITS-1:0] hmem    [HD];

	logic [SW-1:0]         s_w;
	logic [CW-1:0]         cnt_wdata;
	logic [AW-1:0]         h_raddr;
	logic [AW-1:0]         h_waddr;
	logic                  out_valid_q;
	logic                  out_free;

	assign s_w      = SW'(idx_q) + SW'(1);
	assign h_raddr  = base_q + AW'(ptr_q);
	assign h_waddr  = base_q + AW'(cnt_rdata_q);
	assign out_free = !out_valid_q || res.ready;

	// configuration port never stalls
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
			lit_q <= LIT_BUDGET_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MAX_SIZE_LIMIT: lim_q <= cfg.data[SIZE_W-1:0];
				CFG_LITERAL_BUDGET: lit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign req.ready = cmd.req_ready;
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q   <= req.kind;
			handle_q <= req.clause_handle;
			size_q   <= req.clause_size;
			budget_q <= (req.budget > SELECT_CAP) ? SELECT_CAP : req.budget;
		end
	end

	// bucket index and handle base address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			base_q <= '0;
		end else begin
			case (cmd.idx_op)
				IDX_ZERO: begin
					idx_q  <= '0;
					base_q <= '0;
				end
				IDX_SIZE: begin
					idx_q  <= IW'(size_q - SIZE_W'(1));
					base_q <= AW'(AW'(size_q - SIZE_W'(1)) * AW'(BUCKET_DEPTH));
				end
				IDX_INC: begin
					idx_q  <= idx_q + IW'(1);
					base_q <= base_q + AW'(BUCKET_DEPTH);
				end
				default: ;
			endcase
		end
	end

	// count memory, registered read at the current bucket
	always_comb begin
		case (cmd.cnt_wsel)
			CW_ZERO: cnt_wdata = '0;
			CW_INC:  cnt_wdata = cnt_rdata_q + CW'(1);
			CW_DEC:  cnt_wdata = cnt_rdata_q - CW'(1);
			CW_PTR:  cnt_wdata = ptr_q;
			default: cnt_wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_we)
			cnt_mem[idx_q] <= cnt_wdata;
		cnt_rdata_q <= cnt_mem[idx_q];
	end

	// handle memory
	always_ff @(posedge clk) begin
		if (cmd.h_we)
			hmem[h_waddr] <= HANDLE_BITS'(handle_q);
		h_rdata_q <= hmem[h_raddr];
	end

	// arithmetic for the add bound and the whole-bucket test
	always_ff @(posedge clk) begin
		if (cmd.prod_add)
			prod_q <= PRW'(PRW'(cnt_rdata_q + CW'(1)) * PRW'(s_w));
		else if (cmd.prod_sel)
			prod_q <= PRW'(PRW'(cnt_rdata_q) * PRW'(s_w));
	end

	always_ff @(posedge clk) begin
		if (cmd.req_ready && req.valid)
			left_q <= (req.budget > SELECT_CAP) ? SELECT_CAP : req.budget;
		else if (cmd.left_sub_prod)
			left_q <= left_q - BUDGET_W'(prod_q);
		else if (cmd.left_sub_s)
			left_q <= left_q - BUDGET_W'(s_w);

		if (cmd.cw_load)
			cw_q <= cnt_rdata_q;

		case (cmd.ptr_op)
			P_ZERO:   ptr_q <= '0;
			P_CNT_M1: ptr_q <= cnt_rdata_q - CW'(1);
			P_INC:    ptr_q <= ptr_q + CW'(1);
			P_DEC:    ptr_q <= ptr_q - CW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else begin
			case (cmd.total_op)
				T_INC:     total_q <= total_q + TW'(1);
				T_DEC:     total_q <= total_q - TW'(1);
				T_SUB_CNT: total_q <= total_q - TW'(cnt_rdata_q);
				default: ;
			endcase
		end
	end

	// one handle held back so the final result can carry the totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			n_q      <= '0;
		end else if (cmd.sel_init) begin
			pend_v_q <= 1'b0;
			n_q      <= '0;
		end else if (cmd.push) begin
			pend_v_q <= 1'b1;
			n_q      <= n_q + SEL_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pend_handle_q <= h_rdata_q;
			pend_size_q   <= s_w;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res.has_clause     <= 1'b0;
			res.out_handle     <= '0;
			res.out_size       <= '0;
			res.accepted       <= 1'b0;
			res.used_literals  <= '0;
			res.selected_count <= '0;
			res.stored_count   <= '0;
			res.last           <= 1'b1;
			case (cmd.out_sel)
				RES_ACC:    res.accepted <= 1'b1;
				RES_TOTAL:  res.stored_count <= STORED_W'(total_q);
				RES_BUCKET: res.stored_count <= STORED_W'(cnt_rdata_q);
				RES_GIVE: begin
					res.has_clause <= 1'b1;
					res.out_handle <= HANDLE_W'(h_rdata_q);
					res.out_size   <= SIZE_W'(s_w);
					res.accepted   <= 1'b1;
				end
				RES_SEL_ITEM: begin
					res.has_clause <= 1'b1;
					res.out_handle <= HANDLE_W'(pend_handle_q);
					res.out_size   <= SIZE_W'(pend_size_q);
					res.last       <= 1'b0;
				end
				RES_SEL_LAST: begin
					res.has_clause     <= 1'b1;
					res.out_handle     <= HANDLE_W'(pend_handle_q);
					res.out_size       <= SIZE_W'(pend_size_q);
					res.used_literals  <= budget_q - left_q;
					res.selected_count <= n_q;
				end
				default: ;
			endcase
		end
	end
	assign res.valid = out_valid_q;

	// status toward the controller
	always_comb begin
		sts.req_valid = req.valid;
		sts.kind      = kind_q;
		sts.size_zero = (size_q == '0);
		sts.size_over = (32'(size_q) > MAX_SIZE);
		sts.size_ok   = !sts.size_zero && !sts.size_over;
		sts.limit_ok  = (lim_q == '0) || (size_q <= lim_q);
		sts.cnt_zero  = (cnt_rdata_q == '0);
		sts.add_fit   = (32'(cnt_rdata_q) < BUCKET_DEPTH) && (CMPW'(prod_q) < CMPW'(lit_q));
		sts.left_lt_s = (32'(left_q) < 32'(s_w));
		sts.whole_fit = (CMPW'(prod_q) <= CMPW'(left_q));
		sts.ptr_eq_cw = (ptr_q == cw_q);
		sts.idx_last  = (idx_q == IW'(MAX_SIZE - 1));
		sts.pend_v    = pend_v_q;
		sts.out_free  = out_free;
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || res.ready))
		else $error("result register overwritten while held");
	a_push_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && pend_v_q) |-> (cmd.out_load && cmd.out_sel == RES_SEL_ITEM))
		else $error("held handle dropped on push");
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.h_we |-> (32'(cnt_rdata_q) < BUCKET_DEPTH))
		else $error("handle written past bucket depth");

endmodule

// ----- rtl/sbcs_ctrl.sv -----
// Controller: sequences each request over the datapath.
module sbcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  sbcs_pkg::dp_sts_t sts,
	output sbcs_pkg::dp_cmd_t cmd
);
	import sbcs_pkg::*;

	typedef enum logic [21:0] {
		ST_CLR       = 22'h000001,
		ST_IDLE      = 22'h000002,
		ST_DISP      = 22'h000004,
		ST_ADD_RD    = 22'h000008,
		ST_ADD_MUL   = 22'h000010,
		ST_ADD_CHK   = 22'h000020,
		ST_DEL_RD    = 22'h000040,
		ST_DEL_CLR   = 22'h000080,
		ST_BQ_RD     = 22'h000100,
		ST_GIV_RD    = 22'h000200,
		ST_GIV_EVAL  = 22'h000400,
		ST_GIV_HRD   = 22'h000800,
		ST_SEL_RD    = 22'h001000,
		ST_SEL_MUL   = 22'h002000,
		ST_SEL_EVAL  = 22'h004000,
		ST_SEL_WHOLE = 22'h008000,
		ST_SEL_POP   = 22'h010000,
		ST_SEL_HRD   = 22'h020000,
		ST_SEL_PUSH  = 22'h040000,
		ST_SEL_NEXT  = 22'h080000,
		ST_SEL_END   = 22'h100000,
		ST_RES       = 22'h200000
	} state_t;

	state_t state_q, state_d;
	res_t   res_q, res_d;
	logic   pop_q, pop_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		res_d   = res_q;
		pop_d   = pop_q;
		case (state_q)
			ST_CLR: begin
				cmd.cnt_we   = 1'b1;
				cmd.cnt_wsel = CW_ZERO;
				if (sts.idx_last) begin
					cmd.idx_op = IDX_ZERO;
					state_d    = ST_IDLE;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			ST_IDLE: begin
				cmd.req_ready = 1'b1;
				if (sts.req_valid)
					state_d = ST_DISP;
			end
			ST_DISP: begin
				state_d = ST_RES;
				res_d   = RES_NONE;
				case (sts.kind)
					KIND_ADD: begin
						if (sts.size_ok && sts.limit_ok) begin
							cmd.idx_op = IDX_SIZE;
							state_d    = ST_ADD_RD;
						end
					end
					KIND_SELECT: begin
						cmd.idx_op   = IDX_ZERO;
						cmd.sel_init = 1'b1;
						state_d      = ST_SEL_RD;
					end
					KIND_GIVE: begin
						cmd.idx_op = IDX_ZERO;
						state_d    = ST_GIV_RD;
					end
					KIND_DELETE: begin
						if (sts.size_over) begin
							res_d = RES_ACC;
						end else if (!sts.size_zero) begin
							cmd.idx_op = IDX_SIZE;
							state_d    = ST_DEL_RD;
						end
					end
					KIND_TOTAL: res_d = RES_TOTAL;
					KIND_BUCKET: begin
						if (sts.size_ok) begin
							cmd.idx_op = IDX_SIZE;
							state_d    = ST_BQ_RD;
						end
					end
					default: ;
				endcase
			end
			ST_ADD_RD: state_d = ST_ADD_MUL;
			ST_ADD_MUL: begin
				cmd.prod_add = 1'b1;
				state_d      = ST_ADD_CHK;
			end
			ST_ADD_CHK: begin
				state_d = ST_RES;
				if (sts.add_fit) begin
					cmd.h_we     = 1'b1;
					cmd.cnt_we   = 1'b1;
					cmd.cnt_wsel = CW_INC;
					cmd.total_op = T_INC;
					res_d        = RES_ACC;
				end else begin
					res_d = RES_NONE;
				end
			end
			ST_DEL_RD: state_d = ST_DEL_CLR;
			ST_DEL_CLR: begin
				cmd.cnt_we   = 1'b1;
				cmd.cnt_wsel = CW_ZERO;
				cmd.total_op = T_SUB_CNT;
				if (sts.idx_last) begin
					res_d   = RES_ACC;
					state_d = ST_RES;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = ST_DEL_RD;
				end
			end
			ST_BQ_RD: begin
				res_d   = RES_BUCKET;
				state_d = ST_RES;
			end
			ST_GIV_RD: state_d = ST_GIV_EVAL;
			ST_GIV_EVAL: begin
				if (!sts.cnt_zero) begin
					cmd.ptr_op   = P_CNT_M1;
					cmd.cnt_we   = 1'b1;
					cmd.cnt_wsel = CW_DEC;
					cmd.total_op = T_DEC;
					state_d      = ST_GIV_HRD;
				end else if (sts.idx_last) begin
					res_d   = RES_NONE;
					state_d = ST_RES;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = ST_GIV_RD;
				end
			end
			ST_GIV_HRD: begin
				res_d   = RES_GIVE;
				state_d = ST_RES;
			end
			ST_SEL_RD: state_d = ST_SEL_MUL;
			ST_SEL_MUL: begin
				cmd.prod_sel = 1'b1;
				state_d      = sts.left_lt_s ? ST_SEL_END : ST_SEL_EVAL;
			end
			ST_SEL_EVAL: begin
				if (sts.whole_fit) begin
					cmd.cw_load       = 1'b1;
					cmd.ptr_op        = P_ZERO;
					cmd.cnt_we        = 1'b1;
					cmd.cnt_wsel      = CW_ZERO;
					cmd.total_op      = T_SUB_CNT;
					cmd.left_sub_prod = 1'b1;
					pop_d             = 1'b0;
					state_d           = ST_SEL_WHOLE;
				end else begin
					cmd.ptr_op = P_CNT_M1;
					pop_d      = 1'b1;
					state_d    = ST_SEL_POP;
				end
			end
			ST_SEL_WHOLE: state_d = sts.ptr_eq_cw ? ST_SEL_NEXT : ST_SEL_HRD;
			ST_SEL_POP:   state_d = sts.left_lt_s ? ST_SEL_NEXT : ST_SEL_HRD;
			ST_SEL_HRD:   state_d = ST_SEL_PUSH;
			ST_SEL_PUSH: begin
				if (!sts.pend_v || sts.out_free) begin
					cmd.push     = 1'b1;
					cmd.out_load = sts.pend_v;
					cmd.out_sel  = RES_SEL_ITEM;
					if (pop_q) begin
						cmd.cnt_we     = 1'b1;
						cmd.cnt_wsel   = CW_PTR;
						cmd.total_op   = T_DEC;
						cmd.left_sub_s = 1'b1;
						cmd.ptr_op     = P_DEC;
						state_d        = ST_SEL_POP;
					end else begin
						cmd.ptr_op = P_INC;
						state_d    = ST_SEL_WHOLE;
					end
				end
			end
			ST_SEL_NEXT: begin
				if (sts.idx_last) begin
					state_d = ST_SEL_END;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = ST_SEL_RD;
				end
			end
			ST_SEL_END: begin
				res_d   = sts.pend_v ? RES_SEL_LAST : RES_NONE;
				state_d = ST_RES;
			end
			ST_RES: begin
				cmd.out_sel = res_q;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			res_q   <= RES_NONE;
			pop_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			pop_q   <= pop_d;
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.req_ready |-> (state_q == ST_IDLE))
		else $error("request taken outside idle");
	a_clr_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR && sts.idx_last) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not finish");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.h_we |-> (state_q == ST_ADD_CHK && cmd.total_op == T_INC))
		else $error("handle write without count update");

endmodule

// ----- rtl/size_bucketed_clause_store.sv -----
// Size-bucketed clause store top level. An add whose size is refused ends early; a delete
// clears every bucket from the given size up; give-one scans buckets from the smallest (all
// of them when the store is empty); select walks the buckets, passing some and stopping at a
// bucket that stops the walk, and emits one result per handle. Requests: one at a time, the
// next taken only after the result loads; a held result stalls the walk. Reset: async active
// low, then a count clearing pass over all MAX_SIZE buckets.
module size_bucketed_clause_store #(
	parameter int MAX_SIZE     = 32,
	parameter int BUCKET_DEPTH = 1024,
	parameter int HANDLE_BITS  = 16
) (
	input logic        clk,
	input logic        arst_n,
	sbcs_req_if.sink   req,
	sbcs_res_if.source res,
	sbcs_cfg_if.sink   cfg
);
	import sbcs_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Controller: one-hot sequencer, one transaction at a time on the request channel.
	sbcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath: count memory (one entry per size), handle store (BUCKET_DEPTH per size),
	// running total, select budget tracking and the result register.
	sbcs_dp #(
		.MAX_SIZE     (MAX_SIZE),
		.BUCKET_DEPTH (BUCKET_DEPTH),
		.HANDLE_BITS  (HANDLE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
